// File: src/sfrt_pkg.sv
package sfrt_pkg;

    // default table depth and number of links
    localparam int ROUTES_DEF = 16;
    localparam int LINKS      = 8;

    localparam int ADDR_W = 8;
    localparam int LINK_W = 3;
    localparam int CFG_W  = 8;

    typedef enum logic [0:0] {
        OP_ROUTE = 1'b0,
        OP_ADD   = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_LOCAL     = 3'd1,
        ST_FORWARDED = 3'd2,
        ST_BAD       = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_OWN_ADDRESS      = 2'd0,
        REG_LINK_ENABLE_MASK = 2'd1,
        REG_DEFAULT_ENABLE   = 2'd2,
        REG_DEFAULT_LINK     = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH,
        S_DECIDE
    } state_t;

    typedef struct packed {
        opcode_t           opcode;
        logic [ADDR_W-1:0] dest_addr;
        logic [3:0]        new_link;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [LINK_W-1:0] out_link;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0] own_address;
        logic [LINKS-1:0]  link_enable_mask;
        logic              default_enable;
        logic [LINK_W-1:0] default_link;
    } cfg_t;

    // registered read of one table entry
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] dest;
        logic [LINK_W-1:0] link;
    } tbl_rd_t;

    // table write request, index travels beside it
    typedef struct packed {
        logic              en;
        logic              set_valid;
        logic [ADDR_W-1:0] dest;
        logic [LINK_W-1:0] link;
    } tbl_wr_t;

endpackage

// File: src/sfrt_table.sv
module sfrt_table #(
    parameter int ROUTES = sfrt_pkg::ROUTES_DEF,
    parameter int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [IDX_W-1:0]  rd_idx,
    output sfrt_pkg::tbl_rd_t rd,
    input  logic [IDX_W-1:0]  wr_idx,
    input  sfrt_pkg::tbl_wr_t wr
);

    logic [sfrt_pkg::ADDR_W-1:0] dest_mem [ROUTES];
    logic [sfrt_pkg::LINK_W-1:0] link_mem [ROUTES];
    logic [ROUTES-1:0]           valid_reg;
    logic                        rd_valid_reg;
    logic [sfrt_pkg::ADDR_W-1:0] rd_dest_reg;
    logic [sfrt_pkg::LINK_W-1:0] rd_link_reg;

    // entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            link_mem[wr_idx] <= wr.link;
            if (wr.set_valid)
            begin
                dest_mem[wr_idx] <= wr.dest;
            end
        end
        rd_dest_reg <= dest_mem[rd_idx];
        rd_link_reg <= link_mem[rd_idx];
    end

    // valid bits clear at reset so the table starts empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr.set_valid)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    assign rd = {rd_valid_reg, rd_dest_reg, rd_link_reg};

endmodule

// File: src/sfrt_ctrl.sv
module sfrt_ctrl #(
    parameter int ROUTES = sfrt_pkg::ROUTES_DEF,
    parameter int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sfrt_pkg::cmd_t    cmd,
    input  sfrt_pkg::cfg_t    cfg,
    output logic              busy,
    output logic [IDX_W-1:0]  rd_idx,
    input  sfrt_pkg::tbl_rd_t rd,
    output logic [IDX_W-1:0]  wr_idx,
    output sfrt_pkg::tbl_wr_t wr,
    output logic              result_valid,
    output sfrt_pkg::result_t result
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTES - 1);

    sfrt_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0]  scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic              cmp_live_reg;
    sfrt_pkg::cmd_t    cmd_reg;

    logic              found_reg, found_next;
    logic [IDX_W-1:0]  found_idx_reg, found_idx_next;
    logic [sfrt_pkg::LINK_W-1:0] found_link_reg, found_link_next;
    logic              free_reg, free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;

    logic              done_reg, done_next;
    sfrt_pkg::result_t result_reg, result_next;

    logic              accept;
    logic              hit;
    logic              new_usable;
    logic [sfrt_pkg::LINK_W-1:0] fwd_link;
    logic              fwd_have;
    logic              fwd_usable;

    assign accept = start && (state_reg == sfrt_pkg::S_IDLE);
    assign busy   = (state_reg != sfrt_pkg::S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfrt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = sfrt_pkg::S_SCAN;
                end
            end
            sfrt_pkg::S_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = sfrt_pkg::S_FLUSH;
                end
            end
            sfrt_pkg::S_FLUSH:  state_next = sfrt_pkg::S_DECIDE;
            sfrt_pkg::S_DECIDE: state_next = sfrt_pkg::S_IDLE;
            default:            state_next = sfrt_pkg::S_IDLE;
        endcase
    end

    // shared compare unit: one entry per cycle
    assign hit = cmp_live_reg && rd.valid && (rd.dest == cmd_reg.dest_addr);

    always_comb
    begin
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_link_next = found_link_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        if (accept)
        begin
            found_next = 1'b0;
            free_next  = 1'b0;
        end
        else
        begin
            // keep the lowest matching and the lowest free entry
            if (hit && !found_reg)
            begin
                found_next      = 1'b1;
                found_idx_next  = cmp_idx_reg;
                found_link_next = rd.link;
            end
            if (cmp_live_reg && !rd.valid && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = cmp_idx_reg;
            end
        end
    end

    // link checks
    assign new_usable = (cmd_reg.new_link < 4'(sfrt_pkg::LINKS))
                        && cfg.link_enable_mask[cmd_reg.new_link[sfrt_pkg::LINK_W-1:0]];
    assign fwd_have   = found_reg || cfg.default_enable;
    assign fwd_link   = found_reg ? found_link_reg : cfg.default_link;
    assign fwd_usable = ({1'b0, fwd_link} < 4'(sfrt_pkg::LINKS))
                        && cfg.link_enable_mask[fwd_link];

    // outputs: scan address, table write and result
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        rd_idx        = scan_idx_reg;
        wr_idx        = found_idx_reg;
        wr            = '0;
        done_next     = 1'b0;
        result_next   = result_reg;
        case (state_reg)
            sfrt_pkg::S_IDLE:
            begin
                scan_idx_next = '0;
            end
            sfrt_pkg::S_SCAN:
            begin
                if (scan_idx_reg != LAST_IDX)
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            sfrt_pkg::S_FLUSH:
            begin
                scan_idx_next = scan_idx_reg;
            end
            sfrt_pkg::S_DECIDE:
            begin
                done_next            = 1'b1;
                result_next.out_link = '0;
                if (cmd_reg.opcode == sfrt_pkg::OP_ADD)
                begin
                    wr.dest = cmd_reg.dest_addr;
                    wr.link = cmd_reg.new_link[sfrt_pkg::LINK_W-1:0];
                    if (!new_usable)
                    begin
                        result_next.status = sfrt_pkg::ST_BAD;
                    end
                    else if (found_reg)
                    begin
                        wr.en              = 1'b1;
                        result_next.status = sfrt_pkg::ST_OK;
                    end
                    else if (free_reg)
                    begin
                        wr.en              = 1'b1;
                        wr.set_valid       = 1'b1;
                        wr_idx             = free_idx_reg;
                        result_next.status = sfrt_pkg::ST_OK;
                    end
                    else
                    begin
                        result_next.status = sfrt_pkg::ST_FULL;
                    end
                end
                else
                begin
                    if (cmd_reg.dest_addr == cfg.own_address)
                    begin
                        result_next.status = sfrt_pkg::ST_LOCAL;
                    end
                    else if (fwd_have && fwd_usable)
                    begin
                        result_next.status   = sfrt_pkg::ST_FORWARDED;
                        result_next.out_link = fwd_link;
                    end
                    else
                    begin
                        result_next.status = sfrt_pkg::ST_BAD;
                    end
                end
            end
            default:
            begin
                scan_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sfrt_pkg::S_IDLE;
            scan_idx_reg <= '0;
            cmp_live_reg <= 1'b0;
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_live_reg <= (state_reg == sfrt_pkg::S_SCAN);
            found_reg    <= found_next;
            free_reg     <= free_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= scan_idx_reg;
        found_idx_reg  <= found_idx_next;
        found_link_reg <= found_link_next;
        free_idx_reg   <= free_idx_next;
        result_reg     <= result_next;
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    assign result_valid = done_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // every result comes from the decide step
    a_done_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == sfrt_pkg::S_DECIDE))
        else $error("result without decide step");

    // decide always yields a result
    a_decide_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sfrt_pkg::S_DECIDE) |=> done_reg)
        else $error("decide step without result");

    // out_link is clear unless forwarded
    a_link_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.status != sfrt_pkg::ST_FORWARDED)) |-> (result_reg.out_link == '0))
        else $error("out_link set on non-forwarded result");

    // table is only written while deciding an add
    a_write_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> ((state_reg == sfrt_pkg::S_DECIDE) && (cmd_reg.opcode == sfrt_pkg::OP_ADD)
                   && new_usable))
        else $error("table write outside add");

    // a claimed entry was seen free during the scan
    a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && wr.set_valid) |-> (free_reg && !found_reg))
        else $error("claim without free entry");
`endif

endmodule

// File: src/static_frame_route_table_core.sv
// static frame route table: a command starts with start high while busy is low;
// busy then stays high while the table is scanned one entry per cycle through
// a single compare unit (one registered table read port), followed by a flush
// and a decide step; the transaction result appears with result_valid high for
// exactly one cycle, in the first cycle in which busy is low again, and a new
// command may be started in that same cycle; the receiver cannot stall the
// result, it must take it in that cycle; the route table is empty after reset
// through per-entry valid bits, with no clearing pass; configuration writes
// take effect at once and must only be issued while the block is idle
module static_frame_route_table_core #(
    parameter int ROUTES = sfrt_pkg::ROUTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // command side
    input  logic                       start,
    input  sfrt_pkg::cmd_t             cmd,
    output logic                       busy,
    // result side
    output logic                       result_valid,
    output sfrt_pkg::result_t          result,
    // register write port
    input  logic                       wr_en,
    input  logic [1:0]                 wr_index,
    input  logic [sfrt_pkg::CFG_W-1:0] wr_data
);

    // index width into the table
    localparam int IDX_W = (ROUTES > 1) ? $clog2(ROUTES) : 1;

    sfrt_pkg::cfg_t    cfg_reg;
    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  wr_idx;
    sfrt_pkg::tbl_rd_t tbl_rd;
    sfrt_pkg::tbl_wr_t tbl_wr;

    // configuration registers, all reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (sfrt_pkg::reg_index_t'(wr_index))
                sfrt_pkg::REG_OWN_ADDRESS:
                    cfg_reg.own_address <= wr_data[sfrt_pkg::ADDR_W-1:0];
                sfrt_pkg::REG_LINK_ENABLE_MASK:
                    cfg_reg.link_enable_mask <= wr_data[sfrt_pkg::LINKS-1:0];
                sfrt_pkg::REG_DEFAULT_ENABLE:
                    cfg_reg.default_enable <= wr_data[0];
                sfrt_pkg::REG_DEFAULT_LINK:
                    cfg_reg.default_link <= wr_data[sfrt_pkg::LINK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // sequencer with the shared compare unit
    sfrt_ctrl #(
        .ROUTES (ROUTES),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .busy         (busy),
        .rd_idx       (rd_idx),
        .rd           (tbl_rd),
        .wr_idx       (wr_idx),
        .wr           (tbl_wr),
        .result_valid (result_valid),
        .result       (result)
    );

    // route storage with valid bits
    sfrt_table #(
        .ROUTES (ROUTES),
        .IDX_W  (IDX_W)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd     (tbl_rd),
        .wr_idx (wr_idx),
        .wr     (tbl_wr)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int ROUTES    = sfrt_pkg::ROUTES_DEF;
    // settle time after the last result, longer than one command holds the block
    localparam int LAT_CYC   = ROUTES + 8;
    localparam int LIMIT_CYC = 300000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 120;

    typedef struct {
        sfrt_pkg::cmd_t c;
        int unsigned    gap;
    } pending_cmd_t;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              start    = 1'b0;
    sfrt_pkg::cmd_t    cmd      = '0;
    logic              busy;
    logic              result_valid;
    sfrt_pkg::result_t result;
    logic              wr_en    = 1'b0;
    logic [1:0]        wr_index = '0;
    logic [sfrt_pkg::CFG_W-1:0] wr_data = '0;

    // commands waiting for the driver, each with its idle gap
    pending_cmd_t      cmd_pending[$];
    // predicted results, oldest first
    sfrt_pkg::result_t expected_results[$];
    // addresses likely to hit the route table
    logic [sfrt_pkg::ADDR_W-1:0] known_dests[$];

    // shadow of the configuration registers
    logic [sfrt_pkg::ADDR_W-1:0] cfg_own      = '0;
    logic [sfrt_pkg::LINKS-1:0]  cfg_mask     = '0;
    logic                        cfg_def_en   = 1'b0;
    logic [sfrt_pkg::LINK_W-1:0] cfg_def_link = '0;

    // shadow of the route table
    logic                        rt_valid [ROUTES];
    logic [sfrt_pkg::ADDR_W-1:0] rt_dest  [ROUTES];
    logic [sfrt_pkg::LINK_W-1:0] rt_link  [ROUTES];

    int unsigned       sent_cnt = 0;
    int unsigned       done_cnt = 0;
    int unsigned       err_cnt  = 0;
    int unsigned       cyc_cnt  = 0;
    int unsigned       gap_cnt  = 0;
    int                gap_mode = 1;
    pending_cmd_t      next_cmd;
    sfrt_pkg::result_t want;

    static_frame_route_table_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < ROUTES; i++)
        begin
            rt_valid[i] = 1'b0;
            rt_dest[i]  = '0;
            rt_link[i]  = '0;
        end
    end

    // predicts one transaction and updates the shadow table
    function automatic sfrt_pkg::result_t predict_route_result(input sfrt_pkg::cmd_t c);
        sfrt_pkg::result_t           r;
        int                          hit;
        int                          free_slot;
        logic [sfrt_pkg::LINK_W-1:0] lk;
        r.status   = sfrt_pkg::ST_BAD;
        r.out_link = '0;
        hit        = -1;
        free_slot  = -1;
        lk         = '0;
        // lowest valid match and lowest free entry
        for (int i = 0; i < ROUTES; i++)
        begin
            if (hit < 0 && rt_valid[i] && rt_dest[i] == c.dest_addr)
                hit = i;
            if (free_slot < 0 && !rt_valid[i])
                free_slot = i;
        end
        if (c.opcode == sfrt_pkg::OP_ADD)
        begin
            // link must be in range and enabled before the table is touched
            if (c.new_link >= sfrt_pkg::LINKS
                || !cfg_mask[c.new_link[sfrt_pkg::LINK_W-1:0]])
                r.status = sfrt_pkg::ST_BAD;
            else if (hit >= 0)
            begin
                rt_link[hit] = c.new_link[sfrt_pkg::LINK_W-1:0];
                r.status     = sfrt_pkg::ST_OK;
            end
            else if (free_slot >= 0)
            begin
                rt_valid[free_slot] = 1'b1;
                rt_dest[free_slot]  = c.dest_addr;
                rt_link[free_slot]  = c.new_link[sfrt_pkg::LINK_W-1:0];
                r.status            = sfrt_pkg::ST_OK;
            end
            else
                r.status = sfrt_pkg::ST_FULL;
        end
        else if (c.dest_addr == cfg_own)
            // local wins even over a stored route
            r.status = sfrt_pkg::ST_LOCAL;
        else
        begin
            // a stale route does not fall back to the default link
            if (hit >= 0)
                lk = rt_link[hit];
            else
                lk = cfg_def_link;
            if ((hit >= 0 || cfg_def_en) && cfg_mask[lk])
            begin
                r.status   = sfrt_pkg::ST_FORWARDED;
                r.out_link = lk;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        err_cnt++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic push_cmd(input sfrt_pkg::opcode_t op,
                            input logic [sfrt_pkg::ADDR_W-1:0] dest,
                            input logic [3:0] lnk);
        pending_cmd_t p;
        p.c.opcode    = op;
        p.c.dest_addr = dest;
        p.c.new_link  = lnk;
        case (gap_mode)
            0: p.gap = 0;
            1: p.gap = $urandom_range(0, 17);
            default: p.gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 17);
        endcase
        cmd_pending.push_back(p);
        sent_cnt++;
    endtask

    // register writes only happen while no transaction is in flight
    task automatic write_reg(input sfrt_pkg::reg_index_t idx,
                             input logic [sfrt_pkg::CFG_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            sfrt_pkg::REG_OWN_ADDRESS:      cfg_own      = val;
            sfrt_pkg::REG_LINK_ENABLE_MASK: cfg_mask     = val;
            sfrt_pkg::REG_DEFAULT_ENABLE:   cfg_def_en   = val[0];
            sfrt_pkg::REG_DEFAULT_LINK:     cfg_def_link = val[sfrt_pkg::LINK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [sfrt_pkg::ADDR_W-1:0] own,
                              input logic [sfrt_pkg::LINKS-1:0] mask,
                              input logic den,
                              input logic [sfrt_pkg::LINK_W-1:0] dlink);
        write_reg(sfrt_pkg::REG_OWN_ADDRESS, own);
        write_reg(sfrt_pkg::REG_LINK_ENABLE_MASK, mask);
        write_reg(sfrt_pkg::REG_DEFAULT_ENABLE, {7'b0, den});
        write_reg(sfrt_pkg::REG_DEFAULT_LINK, {5'b0, dlink});
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // sender holds off until every expected result is back
    task automatic wait_drained();
        while (done_cnt != sent_cnt)
            @(posedge clk);
        repeat (LAT_CYC) @(posedge clk);
    endtask

    function automatic logic [sfrt_pkg::ADDR_W-1:0] pick_dest();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return known_dests[$urandom_range(0, known_dests.size() - 1)];
        else if (r < 72)
            return cfg_own;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // driver: start stays up across back-to-back transactions,
    // idle gaps are counted once the block is ready again
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start   <= 1'b0;
            cmd     <= '0;
            gap_cnt <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_results.push_back(predict_route_result(cmd));
            if (!busy)
            begin
                if (cmd_pending.size() == 0)
                    start <= 1'b0;
                else if (gap_cnt < cmd_pending[0].gap)
                begin
                    start   <= 1'b0;
                    gap_cnt <= gap_cnt + 1;
                end
                else
                begin
                    next_cmd = cmd_pending.pop_front();
                    start   <= 1'b1;
                    cmd     <= next_cmd.c;
                    gap_cnt <= 0;
                end
            end
        end
    end

    // monitor: one result per strobe, no back-pressure
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected transaction: status %0d link %0d",
                                          result.status, result.out_link));
            else
            begin
                want = expected_results.pop_front();
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              result.status, want.status));
                if (result.out_link !== want.out_link)
                    report_mismatch($sformatf("out_link %0d, expected %0d",
                                              result.out_link, want.out_link));
                done_cnt++;
            end
        end
    end

    always @(posedge clk)
    begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt >= LIMIT_CYC)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        gap_mode = 2;

        // reset config: own address 0, every link disabled, no default
        push_cmd(sfrt_pkg::OP_ROUTE, 8'h00, 4'd0);
        push_cmd(sfrt_pkg::OP_ADD,   8'h12, 4'd1);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'h12, 4'd0);
        wait_drained();

        set_config(8'hA5, 8'hFF, 1'b0, 3'd0);
        push_cmd(sfrt_pkg::OP_ADD,   8'h00, 4'd0);
        push_cmd(sfrt_pkg::OP_ADD,   8'hFF, 4'd7);
        // link out of range
        push_cmd(sfrt_pkg::OP_ADD,   8'h10, 4'd8);
        push_cmd(sfrt_pkg::OP_ADD,   8'h10, 4'd15);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'hFF, 4'd15);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'hA5, 4'd0);
        // route for the own address, still local
        push_cmd(sfrt_pkg::OP_ADD,   8'hA5, 4'd3);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'hA5, 4'd0);
        // replace an existing route
        push_cmd(sfrt_pkg::OP_ADD,   8'h00, 4'd5);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'h00, 4'd0);
        // no route, default off
        push_cmd(sfrt_pkg::OP_ROUTE, 8'h33, 4'd0);
        known_dests = '{8'h00, 8'hFF, 8'hA5};
        // fill the rest of the table, then overflow it
        for (int k = 0; k < ROUTES - 3; k++)
        begin
            push_cmd(sfrt_pkg::OP_ADD, 8'(8'h40 + k), 4'(k % sfrt_pkg::LINKS));
            known_dests.push_back(8'(8'h40 + k));
        end
        push_cmd(sfrt_pkg::OP_ADD, 8'h80, 4'd1);
        push_cmd(sfrt_pkg::OP_ADD, 8'h40, 4'd6);
        known_dests.push_back(8'h80);
        wait_drained();

        // link 7 disabled: stale route, default link used for misses
        set_config(8'h00, 8'h7F, 1'b1, 3'd2);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'hFF, 4'd0);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'h77, 4'd0);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'h00, 4'd0);
        wait_drained();

        // everything disabled, default link disabled
        set_config(8'hFF, 8'h00, 1'b1, 3'd7);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'h77, 4'd0);
        push_cmd(sfrt_pkg::OP_ADD,   8'h01, 4'd7);
        push_cmd(sfrt_pkg::OP_ROUTE, 8'hFF, 4'd0);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == RAND_PHASES - 1)
                set_config(8'hFF, 8'hFF, 1'b1, 3'd0);
            else
                set_config(($urandom_range(0, 3) == 0) ? 8'h00 : pick_dest(),
                           ($urandom_range(0, 3) == 0) ? 8'hFF
                                                       : 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
            // one phase back-to-back, the others with idle gaps
            gap_mode = (ph == 2) ? 0 : $urandom_range(1, 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_cmd(($urandom_range(0, 99) < 40) ? sfrt_pkg::OP_ADD
                                                      : sfrt_pkg::OP_ROUTE,
                         pick_dest(),
                         ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                     : 4'($urandom_range(0, 7)));
            wait_drained();
        end

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d transactions never completed",
                                      expected_results.size()));
        if (err_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
